[sv/lattice_neighbor_capture_table_core_assert.svh]
// Assertion shorthands; the including module provides clk and rst_n.
`ifndef LATTICE_NEIGHBOR_CAPTURE_TABLE_CORE_ASSERT_SVH
`define LATTICE_NEIGHBOR_CAPTURE_TABLE_CORE_ASSERT_SVH

// Checked only outside reset.
`define LNCT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Checked at every edge, reset included.
`define LNCT_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/lnct_pkg.sv]
package lnct_pkg;

  localparam int CAPACITY = 1024;
  localparam int COORD_W  = 11;
  localparam int MESH_W   = 12;
  localparam int REQ_W    = 2;
  localparam int STAT_W   = 3;
  localparam int ENT_W    = 11;
  localparam int NNB      = 8;

  localparam logic [MESH_W-1:0] MESH_RESET = 12'd1581;

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);

  // match reduction groups
  localparam int GRP   = 32;
  localparam int GJ_W  = $clog2(GRP);
  localparam int NGRP  = (CAPACITY + GRP - 1) / GRP;
  localparam int GI_W  = (NGRP > 1) ? $clog2(NGRP) : 1;

  localparam logic [REQ_W-1:0] REQ_APPEND = 2'd0;
  localparam logic [REQ_W-1:0] REQ_QUERY  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd2;

  localparam logic [STAT_W-1:0] ST_APPENDED = 3'd0;
  localparam logic [STAT_W-1:0] ST_CAPTURED = 3'd1;
  localparam logic [STAT_W-1:0] ST_NONE     = 3'd2;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd3;
  localparam logic [STAT_W-1:0] ST_CLEARED  = 3'd4;

  typedef logic [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } site_t;

  typedef struct packed {
    logic [REQ_W-1:0] req_type;
    coord_t           site_x;
    coord_t           site_y;
  } in_item_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    coord_t            found_x;
    coord_t            found_y;
    logic [ENT_W-1:0]  entries_left;
  } out_item_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_WRITE,
    OP_CMP,
    OP_SHIFT
  } cell_op_t;

  // broadcast to every cell
  typedef struct packed {
    cell_op_t               op;
    site_t [NNB-1:0]        cand;
    site_t                  wr;
    logic [IDX_W-1:0]       rm_idx;
  } cell_ctl_t;

  function automatic coord_t lower_of(input coord_t c, input logic [MESH_W-1:0] mesh);
    logic [MESH_W-1:0] m1;
    m1 = mesh - 1'b1;
    if (c == '0) return m1[COORD_W-1:0];
    return c - 1'b1;
  endfunction

  function automatic coord_t upper_of(input coord_t c, input logic [MESH_W-1:0] mesh);
    logic [COORD_W:0] cp1;
    cp1 = {1'b0, c} + 1'b1;
    if ((COORD_W+MESH_W)'(cp1) >= (COORD_W+MESH_W)'(mesh)) return '0;
    return cp1[COORD_W-1:0];
  endfunction

  function automatic logic [2:0] first8(input logic [NNB-1:0] v);
    logic [2:0] r;
    r = '0;
    for (int i = NNB - 1; i >= 0; i--) begin
      if (v[i]) r = 3'(i);
    end
    return r;
  endfunction

  function automatic logic [GJ_W-1:0] first_grp(input logic [GRP-1:0] v);
    logic [GJ_W-1:0] r;
    r = '0;
    for (int i = GRP - 1; i >= 0; i--) begin
      if (v[i]) r = GJ_W'(i);
    end
    return r;
  endfunction

endpackage

[sv/lnct_cell.sv]
module lnct_cell
  import lnct_pkg::*;
(
  input  logic             clk,
  input  logic [IDX_W-1:0] cell_idx,
  input  logic [CNT_W-1:0] count,
  input  cell_ctl_t        ctl,
  input  site_t            nb_entry,
  output site_t            entry,
  output logic [NNB-1:0]   match
);

  site_t            entry_r;
  logic [NNB-1:0]   match_r;
  logic [CNT_W-1:0] my_idx;
  logic             occupied;

  assign my_idx   = CNT_W'(cell_idx);
  assign occupied = my_idx < count;

  always_ff @(posedge clk) begin
    unique case (ctl.op)
      OP_WRITE: begin
        if (my_idx == count) entry_r <= ctl.wr;
      end
      OP_CMP: begin
        for (int n = 0; n < NNB; n++) begin
          match_r[n] <= occupied && (entry_r == ctl.cand[n]);
        end
      end
      OP_SHIFT: begin
        // close the gap: every entry above the removed one moves down a place
        if (my_idx >= CNT_W'(ctl.rm_idx) && (my_idx + 1'b1) < count) entry_r <= nb_entry;
      end
      default: begin
      end
    endcase
  end

  assign entry = entry_r;
  assign match = match_r;

endmodule

[sv/lattice_neighbor_capture_table_core.sv]
// Table of occupied sites on a wrapping square mesh, held in a row of cells,
// one entry per cell. An append goes through S_APPEND (write one cell if the
// table is not full) and S_DONE (load the result register), a clear or reserved
// request straight to S_DONE, and a query passes S_IDX and S_SHIFT only when a neighbor is captured:
// all cells compare against the eight broadcast neighbors at once, two
// registered OR levels over groups of 32 cells find whether and where a
// neighbor hit, S_SEL picks the neighbor and S_IDX the lowest matching cell,
// and S_SHIFT shifts the upper cells down over the removed entry. A new item is
// taken while the previous result waits on out_stall.
// mesh_size may be written through cfg_data only while no item is in flight.
module lattice_neighbor_capture_table_core
  import lnct_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [MESH_W-1:0] cfg_data
);

  `include "lattice_neighbor_capture_table_core_assert.svh"

  typedef enum logic [3:0] {
    S_IDLE,
    S_APPEND,
    S_CMP,
    S_GRP,
    S_ANY,
    S_SEL,
    S_IDX,
    S_SHIFT,
    S_DONE
  } state_t;

  state_t            state_r;
  logic [CNT_W-1:0]  count_r;
  logic [MESH_W-1:0] mesh_r;
  logic              out_valid_r;
  out_item_t         out_data_r;
  out_item_t         res_r;
  site_t             wr_r;
  site_t [NNB-1:0]   cand_r;
  logic [NNB-1:0]    grp_r [NGRP];
  logic [NNB-1:0]    any_r;
  logic [2:0]        sel_n_r;
  logic [GI_W-1:0]   sel_g_r;
  logic [IDX_W-1:0]  rm_idx_r;

  cell_ctl_t         ctl;
  site_t             entry_w [CAPACITY];
  logic [NNB-1:0]    match_w [NGRP][GRP];
  logic [NNB-1:0]    grp_or  [NGRP];
  logic [NNB-1:0]    any_or;
  logic [2:0]        pick_n;
  logic [GI_W-1:0]   pick_g;
  logic [GRP-1:0]    col;
  logic [GJ_W-1:0]   pick_j;
  coord_t            lx, rx, uy, dy;

  // the chain
  for (genvar k = 0; k < NGRP * GRP; k++) begin : g_cell
    if (k < CAPACITY) begin : g_real
      site_t nb;
      if (k + 1 < CAPACITY) begin : g_nb
        assign nb = entry_w[k+1];
      end else begin : g_top
        assign nb = '0;
      end
      lnct_cell u_cell (
        .clk      (clk),
        .cell_idx (IDX_W'(k)),
        .count    (count_r),
        .ctl      (ctl),
        .nb_entry (nb),
        .entry    (entry_w[k]),
        .match    (match_w[k/GRP][k%GRP])
      );
    end else begin : g_pad
      assign match_w[k/GRP][k%GRP] = '0;
    end
  end

  always_comb begin
    ctl        = '0;
    ctl.op     = OP_HOLD;
    ctl.cand   = cand_r;
    ctl.wr     = wr_r;
    ctl.rm_idx = rm_idx_r;
    unique case (state_r)
      S_APPEND: ctl.op = (count_r < CNT_W'(CAPACITY)) ? OP_WRITE : OP_HOLD;
      S_CMP:    ctl.op = OP_CMP;
      S_SHIFT:  ctl.op = OP_SHIFT;
      default:  ctl.op = OP_HOLD;
    endcase
  end

  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_or[g] = '0;
      for (int j = 0; j < GRP; j++) begin
        grp_or[g] = grp_or[g] | match_w[g][j];
      end
    end
    any_or = '0;
    for (int g = 0; g < NGRP; g++) begin
      any_or = any_or | grp_r[g];
    end
  end

  // first neighbor in priority order, then the lowest group holding it
  always_comb begin
    pick_n = first8(any_r);
    pick_g = '0;
    for (int g = NGRP - 1; g >= 0; g--) begin
      if (grp_r[g][pick_n]) pick_g = GI_W'(g);
    end
    for (int j = 0; j < GRP; j++) begin
      col[j] = match_w[sel_g_r][j][sel_n_r];
    end
    pick_j = first_grp(col);
  end

  assign lx = lower_of(in_data.site_x, mesh_r);
  assign rx = upper_of(in_data.site_x, mesh_r);
  assign uy = lower_of(in_data.site_y, mesh_r);
  assign dy = upper_of(in_data.site_y, mesh_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      mesh_r      <= MESH_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) mesh_r <= cfg_data;
      if (out_valid_r && !out_stall && state_r != S_DONE) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            wr_r      <= '{x: in_data.site_x, y: in_data.site_y};
            cand_r[0] <= '{x: lx, y: uy};
            cand_r[1] <= '{x: in_data.site_x, y: uy};
            cand_r[2] <= '{x: rx, y: uy};
            cand_r[3] <= '{x: lx, y: in_data.site_y};
            cand_r[4] <= '{x: rx, y: in_data.site_y};
            cand_r[5] <= '{x: lx, y: dy};
            cand_r[6] <= '{x: in_data.site_x, y: dy};
            cand_r[7] <= '{x: rx, y: dy};
            res_r     <= '{status: (in_data.req_type == REQ_CLEAR) ? ST_CLEARED : ST_NONE,
                           found_x: '0, found_y: '0, entries_left: '0};
            unique case (in_data.req_type)
              REQ_APPEND: state_r <= S_APPEND;
              REQ_QUERY:  state_r <= S_CMP;
              REQ_CLEAR: begin
                count_r <= '0;
                state_r <= S_DONE;
              end
              default:    state_r <= S_DONE;
            endcase
          end
        end
        S_APPEND: begin
          if (count_r < CNT_W'(CAPACITY)) begin
            count_r      <= count_r + 1'b1;
            res_r.status <= ST_APPENDED;
          end else begin
            res_r.status <= ST_FULL;
          end
          state_r <= S_DONE;
        end
        S_CMP: state_r <= S_GRP;
        S_GRP: begin
          for (int g = 0; g < NGRP; g++) grp_r[g] <= grp_or[g];
          state_r <= S_ANY;
        end
        S_ANY: begin
          any_r   <= any_or;
          state_r <= S_SEL;
        end
        S_SEL: begin
          if (any_r == '0) begin
            state_r <= S_DONE;
          end else begin
            sel_n_r       <= pick_n;
            sel_g_r       <= pick_g;
            res_r.status  <= ST_CAPTURED;
            res_r.found_x <= cand_r[pick_n].x;
            res_r.found_y <= cand_r[pick_n].y;
            state_r       <= S_IDX;
          end
        end
        S_IDX: begin
          rm_idx_r <= IDX_W'(int'(sel_g_r) * GRP + int'(pick_j));
          state_r  <= S_SHIFT;
        end
        S_SHIFT: begin
          count_r <= count_r - 1'b1;
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_data_r  <= '{status: res_r.status, found_x: res_r.found_x,
                             found_y: res_r.found_y, entries_left: ENT_W'(count_r)};
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `LNCT_ASSERT(a_count_cap, (count_r <= CNT_W'(CAPACITY)), "entry count above capacity")
  `LNCT_ASSERT(a_rm_in_range, state_r == S_SHIFT |-> CNT_W'(rm_idx_r) < count_r, "stale rm index")
  `LNCT_ASSERT(a_shift_dec, state_r == S_SHIFT |=> count_r == $past(count_r) - 1'b1, "no decrement")
  `LNCT_ASSERT(a_beat_from_done, $rose(out_valid_r) |-> $past(state_r == S_DONE), "stray beat")
  `LNCT_ASSERT_RST(a_reset_idle, !rst_n |=> state_r == S_IDLE && !out_valid_r, "reset left a beat")
  `LNCT_ASSERT_RST(a_reset_count, !rst_n |=> count_r == '0, "reset left entries")

endmodule

[dv/lattice_neighbor_capture_table_core_test.sv]
module lattice_neighbor_capture_table_core_test;
  import lnct_pkg::*;

  localparam logic [REQ_W-1:0] REQ_RESERVED = 2'd3;
  localparam int N_DIRECTED = 20;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 16;

  typedef struct packed {
    in_item_t  item;
    logic      typed;
    out_item_t want;
  } dir_row_t;

  // typed expectations only where the answer is obvious; the rest come from the predictor
  localparam dir_row_t DIRECTED [N_DIRECTED] = '{
    '{'{REQ_QUERY,    11'd0,    11'd0},    1'b1, '{ST_NONE,     11'd0, 11'd0, 11'd0}},
    '{'{REQ_RESERVED, 11'd2047, 11'd2047}, 1'b1, '{ST_NONE,     11'd0, 11'd0, 11'd0}},
    '{'{REQ_APPEND,   11'd0,    11'd0},    1'b1, '{ST_APPENDED, 11'd0, 11'd0, 11'd1}},
    '{'{REQ_APPEND,   11'd1580, 11'd1580}, 1'b1, '{ST_APPENDED, 11'd0, 11'd0, 11'd2}},
    '{'{REQ_APPEND,   11'd2047, 11'd2047}, 1'b1, '{ST_APPENDED, 11'd0, 11'd0, 11'd3}},
    '{'{REQ_APPEND,   11'd1,    11'd0},    1'b1, '{ST_APPENDED, 11'd0, 11'd0, 11'd4}},
    '{'{REQ_APPEND,   11'd1,    11'd0},    1'b1, '{ST_APPENDED, 11'd0, 11'd0, 11'd5}},
    '{'{REQ_APPEND,   11'd1580, 11'd0},    1'b1, '{ST_APPENDED, 11'd0, 11'd0, 11'd6}},
    // low-edge wrap on both axes, then walk down the priority order
    '{'{REQ_QUERY,    11'd0,    11'd0},    1'b0, '0},
    '{'{REQ_QUERY,    11'd0,    11'd0},    1'b0, '0},
    '{'{REQ_QUERY,    11'd0,    11'd0},    1'b0, '0},
    '{'{REQ_QUERY,    11'd0,    11'd0},    1'b0, '0},
    '{'{REQ_QUERY,    11'd0,    11'd0},    1'b0, '0},
    // beyond the mesh: high-edge wrap lands on 0
    '{'{REQ_QUERY,    11'd2047, 11'd2047}, 1'b0, '0},
    '{'{REQ_RESERVED, 11'd0,    11'd0},    1'b0, '0},
    '{'{REQ_APPEND,   11'd2047, 11'd0},    1'b0, '0},
    '{'{REQ_QUERY,    11'd2047, 11'd1},    1'b0, '0},
    '{'{REQ_CLEAR,    11'd1234, 11'd567},  1'b1, '{ST_CLEARED,  11'd0, 11'd0, 11'd0}},
    '{'{REQ_QUERY,    11'd1,    11'd1},    1'b1, '{ST_NONE,     11'd0, 11'd0, 11'd0}},
    '{'{REQ_APPEND,   11'd2047, 11'd2047}, 1'b1, '{ST_APPENDED, 11'd0, 11'd0, 11'd1}}
  };

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  in_item_t          in_data = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  out_item_t         out_data;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [MESH_W-1:0] cfg_data = '0;

  // predictor state
  logic [MESH_W-1:0] mesh_sz = MESH_RESET;
  site_t             site_tab[$];
  out_item_t         awaited_results[$];

  int idle_mode = 0;
  int n_fail = 0;
  int quiet_cycles = 0;

  lattice_neighbor_capture_table_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic coord_t wrap_dec(coord_t c);
    logic [MESH_W-1:0] m1;
    m1 = mesh_sz - 12'd1;
    if (c == '0) return m1[COORD_W-1:0];
    return c - 1'b1;
  endfunction

  function automatic coord_t wrap_inc(coord_t c);
    if (32'(c) + 32'd1 >= 32'(mesh_sz)) return '0;
    return c + 1'b1;
  endfunction

  // applies one request to the site table and returns the answer
  function automatic out_item_t table_step(in_item_t rq);
    out_item_t res;
    site_t     cand[NNB];
    coord_t    xl, xr, yu, yd;
    bit        hit;
    res = '0;
    res.status = ST_NONE;
    case (rq.req_type)
      REQ_APPEND: begin
        if (site_tab.size() >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          site_tab.push_back({rq.site_x, rq.site_y});
          res.status = ST_APPENDED;
        end
      end
      REQ_QUERY: begin
        xl = wrap_dec(rq.site_x);
        xr = wrap_inc(rq.site_x);
        yu = wrap_dec(rq.site_y);
        yd = wrap_inc(rq.site_y);
        cand[0] = {xl, yu};
        cand[1] = {rq.site_x, yu};
        cand[2] = {xr, yu};
        cand[3] = {xl, rq.site_y};
        cand[4] = {xr, rq.site_y};
        cand[5] = {xl, yd};
        cand[6] = {rq.site_x, yd};
        cand[7] = {xr, yd};
        hit = 1'b0;
        for (int n = 0; n < NNB && !hit; n++) begin
          for (int k = 0; k < site_tab.size() && !hit; k++) begin
            if (site_tab[k] == cand[n]) begin
              site_tab.delete(k);
              hit = 1'b1;
              res.status = ST_CAPTURED;
              res.found_x = cand[n].x;
              res.found_y = cand[n].y;
            end
          end
        end
      end
      REQ_CLEAR: begin
        site_tab.delete();
        res.status = ST_CLEARED;
      end
      default: ;
    endcase
    res.entries_left = ENT_W'(site_tab.size());
    return res;
  endfunction

  function automatic coord_t rand_coord();
    int unsigned top;
    top = (mesh_sz >= 1 && mesh_sz <= 2048) ? 32'(mesh_sz) - 1 : 2047;
    if ($urandom_range(0, 4) == 0) return coord_t'($urandom_range(0, 2047));
    return coord_t'($urandom_range(0, top));
  endfunction

  function automatic coord_t near_coord(coord_t c);
    case ($urandom_range(0, 2))
      0: return wrap_dec(c);
      1: return c;
      default: return wrap_inc(c);
    endcase
  endfunction

  // mostly appends and queries aimed next to occupied sites, so captures happen often
  function automatic in_item_t pick_request();
    in_item_t    rq;
    site_t       e;
    int unsigned r;
    r = $urandom_range(0, 99);
    rq.site_x = rand_coord();
    rq.site_y = rand_coord();
    if (r < 2) begin
      rq.req_type = REQ_CLEAR;
    end else if (r < 6) begin
      rq.req_type = REQ_RESERVED;
    end else begin
      rq.req_type = (r < 52) ? REQ_APPEND : REQ_QUERY;
      if (site_tab.size() > 0 && $urandom_range(0, 99) < (r < 52 ? 35 : 80)) begin
        e = site_tab[$urandom_range(0, site_tab.size() - 1)];
        rq.site_x = near_coord(e.x);
        rq.site_y = near_coord(e.y);
      end
    end
    return rq;
  endfunction

  task automatic send(in_item_t rq, logic typed, out_item_t want);
    int pct;
    out_item_t res;
    pct = (idle_mode == 0) ? 16 : (idle_mode == 1) ? 71 : 0;
    while ($urandom_range(0, 99) < pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= rq;
    do @(posedge clk); while (in_stall);
    res = table_step(rq);
    awaited_results.push_back(typed ? want : res);
  endtask

  // register writes only with nothing in flight
  task automatic set_mesh(logic [MESH_W-1:0] m);
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    mesh_sz = m;
  endtask

  task automatic run_phase(logic [MESH_W-1:0] m, int mode, int n_items);
    set_mesh(m);
    idle_mode = mode;
    repeat (n_items) send(pick_request(), 1'b0, '0);
    in_valid <= 1'b0;
  endtask

  task automatic report_field(string name, int unsigned want, int unsigned got);
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    n_fail++;
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, got %h", $time, out_data);
        n_fail++;
      end else begin
        want = awaited_results.pop_front();
        if (out_data.status !== want.status)
          report_field("status", want.status, out_data.status);
        if (out_data.found_x !== want.found_x)
          report_field("found_x", want.found_x, out_data.found_x);
        if (out_data.found_y !== want.found_y)
          report_field("found_y", want.found_y, out_data.found_y);
        if (out_data.entries_left !== want.entries_left)
          report_field("entries_left", want.entries_left, out_data.entries_left);
      end
    end
    case (idle_mode)
      0: out_stall <= ($urandom_range(0, 99) < 71);
      1: out_stall <= ($urandom_range(0, 99) < 16);
      default: out_stall <= 1'b0;
    endcase
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("lattice_neighbor_capture_table_core test failed");
        $finish;
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    idle_mode = 0;
    for (int i = 0; i < N_DIRECTED; i++)
      send(DIRECTED[i].item, DIRECTED[i].typed, DIRECTED[i].want);
    in_valid <= 1'b0;

    // sender idles lightly, receiver heavily
    run_phase(12'd3, 0, 60);
    run_phase(12'd2048, 0, 60);
    run_phase(12'd5, 0, 50);
    run_phase(12'd0, 0, 40);
    // and the other way round
    run_phase(12'd4095, 1, 50);
    run_phase(12'd1, 1, 40);
    run_phase(12'd2, 1, 40);
    run_phase(12'd7, 1, 50);
    // back to back
    run_phase(MESH_W'($urandom_range(3, 2048)), 2, 60);
    run_phase(MESH_RESET, 2, 60);

    // clear, then a short burst on a mesh of 2048
    set_mesh(12'd2048);
    idle_mode = 2;
    send('{REQ_CLEAR, coord_t'(0), coord_t'(0)}, 1'b0, '0);
    repeat (3) send('{REQ_APPEND, rand_coord(), rand_coord()}, 1'b0, '0);
    send('{REQ_QUERY, near_coord(site_tab[0].x), near_coord(site_tab[0].y)}, 1'b0, '0);
    repeat (2) send('{REQ_APPEND, rand_coord(), rand_coord()}, 1'b0, '0);
    repeat (30) send(pick_request(), 1'b0, '0);
    in_valid <= 1'b0;

    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (n_fail == 0 && awaited_results.size() == 0)
      $display("lattice_neighbor_capture_table_core test passed");
    else
      $display("lattice_neighbor_capture_table_core test failed");
    $finish;
  end

endmodule
